// File: sv/ps2m_pkg.sv
// Shared types, codes and constants of the PS/2 mouse packet decoder.
package ps2m_pkg;

    // Default cursor coordinate width and the fixed width of reported positions
    localparam int COORD_BITS_DEF = 16;
    localparam int POS_BITS       = 16;

    // Request actions
    localparam logic ACT_BYTE    = 1'b0;
    localparam logic ACT_RESTART = 1'b1;

    // Event kinds
    localparam logic [1:0] EVT_MOVE = 2'd0;
    localparam logic [1:0] EVT_DOWN = 2'd1;
    localparam logic [1:0] EVT_UP   = 2'd2;

    // Button numbers
    localparam logic [1:0] BTN_LEFT   = 2'd0;
    localparam logic [1:0] BTN_RIGHT  = 2'd1;
    localparam logic [1:0] BTN_MIDDLE = 2'd2;

    // Register map (index = paddr[3:2])
    localparam int         ADDR_BITS  = 4;
    localparam logic [1:0] REG_ENABLE = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam logic [15:0] WIDTH_RESET  = 16'd640;
    localparam logic [15:0] HEIGHT_RESET = 16'd480;

    // Packet queue between decoder and event sequencer
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic        enable;
        logic [15:0] width;
        logic [15:0] height;
    } cfg_t;

    // One decoded packet: resulting state plus the events still to emit
    typedef struct packed {
        logic [15:0]        pos_x;
        logic [15:0]        pos_y;
        logic signed [7:0]  delta_x;
        logic signed [8:0]  delta_y;
        logic [2:0]         mask;
        logic [2:0]         changed;
        logic               moved;
    } packet_t;

endpackage

// File: sv/ps2m_if.sv
// Valid/ready channel interfaces for mouse requests and cursor events.
interface ps2m_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] data_byte;

    modport source (output valid, action, data_byte, input ready);
    modport sink   (input valid, action, data_byte, output ready);
endinterface

interface ps2m_out_if;
    logic              valid;
    logic              ready;
    logic [1:0]        event_kind;
    logic [15:0]       pos_x;
    logic [15:0]       pos_y;
    logic signed [7:0] delta_x;
    logic signed [8:0] delta_y;
    logic [1:0]        which_button;
    logic [2:0]        button_mask;
    logic              last;

    modport source (output valid, event_kind, pos_x, pos_y, delta_x, delta_y,
                    which_button, button_mask, last, input ready);
    modport sink   (input valid, event_kind, pos_x, pos_y, delta_x, delta_y,
                    which_button, button_mask, last, output ready);
endinterface

// File: sv/ps2_mouse_packet_to_cursor_events.sv
// PS/2 mouse packet decoder producing cursor move and button events.
// A packet's third byte passes the packet queue, then the sequencer's packet and output registers.
// Throughput: one request per cycle while the two-entry packet queue has room; the event
// sequencer sends events at one per cycle while events.ready holds, up to four per packet.
// Reset clears packet position, cursor, buttons, queue and output; enable 0, 640 x 480.
module ps2_mouse_packet_to_cursor_events #(
    parameter int COORD_BITS = ps2m_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    ps2m_in_if.sink                       mouse,
    ps2m_out_if.source                    events,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ps2m_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import ps2m_pkg::*;

    logic        enable_reg;
    logic [15:0] width_reg;
    logic [15:0] height_reg;
    logic        cfg_wr;
    logic [1:0]  reg_idx;
    cfg_t        cfg;

    logic        push;
    packet_t     push_data;
    logic        queue_full;
    logic        pop;
    logic        queue_valid;
    packet_t     queue_data;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_ENABLE: enable_reg <= pwdata[0];
                REG_WIDTH:  width_reg  <= pwdata[15:0];
                REG_HEIGHT: height_reg <= pwdata[15:0];
                default:    enable_reg <= enable_reg;
            endcase
        end
    end

    // Read back configuration registers
    always_comb
    begin
        unique case (reg_idx)
            REG_ENABLE: prdata = {31'd0, enable_reg};
            REG_WIDTH:  prdata = {16'd0, width_reg};
            REG_HEIGHT: prdata = {16'd0, height_reg};
            default:    prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg.enable = enable_reg;
        cfg.width  = width_reg;
        cfg.height = height_reg;
    end

    ps2m_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .mouse      (mouse),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    ps2m_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .pop_valid (queue_valid),
        .pop_data  (queue_data)
    );

    ps2m_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_valid (queue_valid),
        .queue_data  (queue_data),
        .pop         (pop),
        .events      (events)
    );

endmodule

// File: sv/ps2m_fifo.sv
// Short packet queue between the byte decoder and the event sequencer.
module ps2m_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ps2m_pkg::packet_t push_data,
    output logic              full,
    input  logic              pop,
    output logic              pop_valid,
    output ps2m_pkg::packet_t pop_data
);
    import ps2m_pkg::*;

    packet_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign pop_valid = (cnt_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    // Advance pointers with wrap and track the fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the incoming packet
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: sv/ps2m_front.sv
// Byte decoder: assembles packets, updates cursor and buttons, queues packets.
module ps2m_front #(
    parameter int COORD_BITS = ps2m_pkg::COORD_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ps2m_pkg::cfg_t    cfg,
    ps2m_in_if.sink           mouse,
    input  logic              queue_full,
    output logic              push,
    output ps2m_pkg::packet_t push_data
);
    import ps2m_pkg::*;

    // Working width for signed coordinate arithmetic
    localparam int SW = ((COORD_BITS > POS_BITS) ? COORD_BITS : POS_BITS) + 2;
    localparam logic [SW-1:0] CMAX = {{(SW - COORD_BITS){1'b0}}, {COORD_BITS{1'b1}}};

    // Packet position codes
    localparam logic [1:0] POS_HEAD = 2'd0;
    localparam logic [1:0] POS_DX   = 2'd1;
    localparam logic [1:0] POS_DY   = 2'd2;

    logic [1:0]            bpos_reg, bpos_next;
    logic [7:0]            head_reg;
    logic [7:0]            dx_reg;
    logic [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic [2:0]            btn_reg, btn_next;

    logic                  take;
    logic                  data_take;
    logic                  complete;
    logic                  head_ok;
    logic                  zero_screen;
    logic                  moved;
    logic [2:0]            changed;
    logic signed [SW-1:0]  sum_x;
    logic signed [SW-1:0]  sum_y;
    logic [COORD_BITS-1:0] new_x;
    logic [COORD_BITS-1:0] new_y;
    logic [SW-1:0]         half_x;
    logic [SW-1:0]         half_y;
    logic [COORD_BITS-1:0] mid_x;
    logic [COORD_BITS-1:0] mid_y;
    logic [SW-1:0]         new_x_ext;
    logic [SW-1:0]         new_y_ext;

    // Limit a coordinate to [0, size-1] and to the coordinate range
    function automatic logic [COORD_BITS-1:0] clamp(input logic signed [SW-1:0] v,
                                                    input logic [15:0] size);
        logic signed [SW-1:0] hi;
        logic [COORD_BITS-1:0] r;
        hi = $signed({{(SW - 16){1'b0}}, size}) - $signed(SW'(1));
        if (hi > $signed(CMAX))
        begin
            hi = $signed(CMAX);
        end
        if (v < $signed(SW'(0)))
        begin
            r = '0;
        end
        else if (v > hi)
        begin
            r = hi[COORD_BITS-1:0];
        end
        else
        begin
            r = v[COORD_BITS-1:0];
        end
        return r;
    endfunction

    assign mouse.ready = !queue_full;
    assign take        = mouse.valid && mouse.ready;
    assign data_take   = take && (mouse.action == ACT_BYTE) && cfg.enable;
    assign complete    = data_take && (bpos_reg == POS_DY);
    assign head_ok     = (head_reg[7:6] == 2'b00);
    assign zero_screen = (cfg.width == '0) || (cfg.height == '0);

    // Move by (dx, -dy) and clamp to the screen
    assign sum_x = $signed({{(SW - COORD_BITS){1'b0}}, cur_x_reg})
                 + $signed({{(SW - 8){dx_reg[7]}}, dx_reg});
    assign sum_y = $signed({{(SW - COORD_BITS){1'b0}}, cur_y_reg})
                 - $signed({{(SW - 8){mouse.data_byte[7]}}, mouse.data_byte});
    assign new_x = zero_screen ? '0 : clamp(sum_x, cfg.width);
    assign new_y = zero_screen ? '0 : clamp(sum_y, cfg.height);

    // Centre position for restart, saturated to the coordinate range
    assign half_x = {{(SW - 15){1'b0}}, cfg.width[15:1]};
    assign half_y = {{(SW - 15){1'b0}}, cfg.height[15:1]};
    assign mid_x  = (half_x > CMAX) ? CMAX[COORD_BITS-1:0] : half_x[COORD_BITS-1:0];
    assign mid_y  = (half_y > CMAX) ? CMAX[COORD_BITS-1:0] : half_y[COORD_BITS-1:0];

    // Classify the packet and build the queue record
    assign changed   = btn_reg ^ head_reg[2:0];
    assign moved     = (dx_reg != '0) || (mouse.data_byte != '0);
    assign push      = complete && head_ok && (moved || (changed != '0));
    assign new_x_ext = {{(SW - COORD_BITS){1'b0}}, new_x};
    assign new_y_ext = {{(SW - COORD_BITS){1'b0}}, new_y};

    always_comb
    begin
        push_data.pos_x   = new_x_ext[POS_BITS-1:0];
        push_data.pos_y   = new_y_ext[POS_BITS-1:0];
        push_data.delta_x = $signed(dx_reg);
        push_data.delta_y = $signed(9'd0) - $signed({mouse.data_byte[7], mouse.data_byte});
        push_data.mask    = head_reg[2:0];
        push_data.changed = changed;
        push_data.moved   = moved;
    end

    // Next state for packet position, cursor and buttons
    always_comb
    begin
        bpos_next  = bpos_reg;
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        btn_next   = btn_reg;
        if (take && (mouse.action == ACT_RESTART))
        begin
            bpos_next  = POS_HEAD;
            cur_x_next = mid_x;
            cur_y_next = mid_y;
            btn_next   = '0;
        end
        else if (data_take)
        begin
            unique case (bpos_reg)
                POS_HEAD:
                begin
                    if (mouse.data_byte[3])
                    begin
                        bpos_next = POS_DX;
                    end
                end
                POS_DX:
                begin
                    bpos_next = POS_DY;
                end
                POS_DY:
                begin
                    bpos_next = POS_HEAD;
                    if (head_ok)
                    begin
                        cur_x_next = new_x;
                        cur_y_next = new_y;
                        btn_next   = head_reg[2:0];
                    end
                end
                default:
                begin
                    bpos_next = POS_HEAD;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpos_reg  <= POS_HEAD;
            cur_x_reg <= '0;
            cur_y_reg <= '0;
            btn_reg   <= '0;
        end
        else
        begin
            bpos_reg  <= bpos_next;
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
            btn_reg   <= btn_next;
        end
    end

    // Hold the first two bytes of the packet
    always_ff @(posedge clk)
    begin
        if (data_take && (bpos_reg == POS_HEAD) && mouse.data_byte[3])
        begin
            head_reg <= mouse.data_byte;
        end
        if (data_take && (bpos_reg == POS_DX))
        begin
            dx_reg <= mouse.data_byte;
        end
    end

endmodule

// File: sv/ps2m_back.sv
// Event sequencer: expands each queued packet into move and button events.
module ps2m_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              queue_valid,
    input  ps2m_pkg::packet_t queue_data,
    output logic              pop,
    ps2m_out_if.source        events
);
    import ps2m_pkg::*;

    // Pending events: bit 0 move, bits 1..3 left, right, middle change
    logic [3:0]        pend_reg, pend_next;
    logic [3:0]        lowest;
    logic [3:0]        pend_rest;
    packet_t           pkt_reg;
    logic              ov_reg, ov_next;
    logic              emit;

    logic [1:0]        kind_reg, kind_next;
    logic [15:0]       posx_reg;
    logic [15:0]       posy_reg;
    logic signed [7:0] dx_reg, dx_next;
    logic signed [8:0] dy_reg, dy_next;
    logic [1:0]        which_reg, which_next;
    logic [2:0]        mask_reg;
    logic              last_reg;

    assign lowest    = pend_reg & (~pend_reg + 4'd1);
    assign pend_rest = pend_reg & ~lowest;
    assign emit      = (pend_reg != '0) && (!ov_reg || events.ready);
    assign pop       = queue_valid && ((pend_reg == '0) || (emit && (pend_rest == '0)));

    // Pick the next event of the current packet
    always_comb
    begin
        kind_next  = EVT_MOVE;
        dx_next    = '0;
        dy_next    = '0;
        which_next = BTN_LEFT;
        case (lowest)
            4'b0001:
            begin
                dx_next = pkt_reg.delta_x;
                dy_next = pkt_reg.delta_y;
            end
            4'b0010:
            begin
                kind_next  = pkt_reg.mask[0] ? EVT_DOWN : EVT_UP;
                which_next = BTN_LEFT;
            end
            4'b0100:
            begin
                kind_next  = pkt_reg.mask[1] ? EVT_DOWN : EVT_UP;
                which_next = BTN_RIGHT;
            end
            4'b1000:
            begin
                kind_next  = pkt_reg.mask[2] ? EVT_DOWN : EVT_UP;
                which_next = BTN_MIDDLE;
            end
            default:
            begin
                kind_next = EVT_MOVE;
            end
        endcase
    end

    // Load a new packet or retire the emitted event; track the output slot
    always_comb
    begin
        pend_next = pend_reg;
        if (pop)
        begin
            pend_next = {queue_data.changed, queue_data.moved};
        end
        else if (emit)
        begin
            pend_next = pend_rest;
        end

        ov_next = ov_reg;
        if (emit)
        begin
            ov_next = 1'b1;
        end
        else if (events.ready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            ov_reg   <= ov_next;
        end
    end

    // Capture packet and output event payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            pkt_reg <= queue_data;
        end
        if (emit)
        begin
            kind_reg  <= kind_next;
            posx_reg  <= pkt_reg.pos_x;
            posy_reg  <= pkt_reg.pos_y;
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            which_reg <= which_next;
            mask_reg  <= pkt_reg.mask;
            last_reg  <= (pend_rest == '0);
        end
    end

    assign events.valid        = ov_reg;
    assign events.event_kind   = kind_reg;
    assign events.pos_x        = posx_reg;
    assign events.pos_y        = posy_reg;
    assign events.delta_x      = dx_reg;
    assign events.delta_y      = dy_reg;
    assign events.which_button = which_reg;
    assign events.button_mask  = mask_reg;
    assign events.last         = last_reg;

endmodule
